>>> rtl/radix_prefixed_literal_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix-prefixed literal parser
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_PREFIXED_LITERAL_PARSER_ASSERT_SVH
`define RADIX_PREFIXED_LITERAL_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RPLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rplp_pkg.sv
// ----------------------------------------------------------------------------
// rplp_pkg
// Types, codes and digit decode shared by the literal parser modules.
// ----------------------------------------------------------------------------
package rplp_pkg;

  // parser phase codes
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_e;

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef struct packed {
    logic [1:0]  phase;
    logic [63:0] acc;
    logic [7:0]  cnt;
    radix_e      radix;
    logic        us_ok;
  } rplp_state_t;

  localparam rplp_state_t STATE_RESET = '{
    phase: PH_SKIP, acc: 64'd0, cnt: 8'd0, radix: RX_DEC, us_ok: 1'b0
  };

  // Digit value of c in the given radix, DIGIT_NONE when it is no such digit.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input radix_e r);
    logic [4:0] d;
    logic [4:0] lim;
    begin
      d = DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = 5'(c - 8'h37);
      end
      unique case (r)
        RX_HEX:  lim = 5'd16;
        RX_OCT:  lim = 5'd8;
        RX_BIN:  lim = 5'd2;
        default: lim = 5'd10;
      endcase
      if (d >= lim) begin
        d = DIGIT_NONE;
      end
      return d;
    end
  endfunction

endpackage

>>> rtl/rplp_step.sv
// ----------------------------------------------------------------------------
// rplp_step
// Next-state logic of the parser for one character: phase, accumulator,
// count and radix, plus the flag that the character terminates the literal.
// ----------------------------------------------------------------------------
module rplp_step #(
  parameter logic [7:0] CountCap = 8'd255
) (
  input  rplp_pkg::rplp_state_t state_i,
  input  logic [7:0]            char_i,
  input  logic                  start_i,
  output rplp_pkg::rplp_state_t state_o,
  output logic                  emit_o
);
  import rplp_pkg::*;

  rplp_state_t s;
  logic [7:0]  cnt_inc;
  logic [4:0]  dig;
  logic [63:0] acc_next;
  logic        is_space;

  assign s        = start_i ? STATE_RESET : state_i;
  assign cnt_inc  = (s.cnt < CountCap) ? s.cnt + 8'd1 : s.cnt;
  assign dig      = digit_value(char_i, s.radix);
  assign is_space = (char_i == 8'h20) || (char_i >= 8'd9 && char_i <= 8'd13);

  always_comb begin
    unique case (s.radix)
      RX_HEX:  acc_next = {s.acc[59:0], 4'd0} + 64'(dig[3:0]);
      RX_OCT:  acc_next = {s.acc[60:0], 3'd0} + 64'(dig[3:0]);
      RX_BIN:  acc_next = {s.acc[62:0], 1'd0} + 64'(dig[3:0]);
      default: acc_next = {s.acc[60:0], 3'd0} + {s.acc[62:0], 1'd0} + 64'(dig[3:0]);
    endcase
  end

  always_comb begin
    state_o = s;
    emit_o  = 1'b0;
    unique case (s.phase)
      PH_SKIP: begin
        priority if (is_space) begin
          state_o.cnt = cnt_inc;
        end else if (char_i == 8'h25) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_BIN;
          state_o.us_ok = 1'b1;
          state_o.phase = PH_DIGITS;
        end else if (char_i == 8'h24) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_HEX;
          state_o.us_ok = 1'b1;
          state_o.phase = PH_DIGITS;
        end else if (char_i == 8'h30) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_OCT;
          state_o.phase = PH_ZERO;
        end else if (char_i >= 8'h31 && char_i <= 8'h39) begin
          state_o.cnt   = cnt_inc;
          state_o.acc   = 64'(char_i[3:0]);
          state_o.radix = RX_DEC;
          state_o.us_ok = 1'b0;
          state_o.phase = PH_DIGITS;
        end else begin
          state_o.radix = RX_DEC;
          state_o.phase = PH_DONE;
          emit_o        = 1'b1;
        end
      end
      PH_ZERO: begin
        priority if (char_i == 8'h78 || char_i == 8'h58) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_HEX;
          state_o.us_ok = 1'b1;
          state_o.phase = PH_DIGITS;
        end else if (char_i == 8'h6F || char_i == 8'h4F) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_OCT;
          state_o.us_ok = 1'b1;
          state_o.phase = PH_DIGITS;
        end else if (char_i == 8'h62 || char_i == 8'h42) begin
          state_o.cnt   = cnt_inc;
          state_o.radix = RX_BIN;
          state_o.us_ok = 1'b1;
          state_o.phase = PH_DIGITS;
        end else if (char_i >= 8'h30 && char_i <= 8'h37) begin
          state_o.cnt   = cnt_inc;
          state_o.acc   = 64'(char_i[2:0]);
          state_o.radix = RX_OCT;
          state_o.us_ok = 1'b0;
          state_o.phase = PH_DIGITS;
        end else begin
          state_o.phase = PH_DONE;
          emit_o        = 1'b1;
        end
      end
      PH_DIGITS: begin
        priority if (char_i == 8'h5F && s.us_ok) begin
          state_o.cnt = cnt_inc;
        end else if (dig != DIGIT_NONE) begin
          state_o.cnt = cnt_inc;
          state_o.acc = acc_next;
        end else begin
          state_o.phase = PH_DONE;
          emit_o        = 1'b1;
        end
      end
      default: begin
        // terminated: swallow characters until the next start
        state_o.phase = PH_DONE;
      end
    endcase
  end

endmodule

>>> rtl/radix_prefixed_literal_parser.sv
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser
// Parses an unsigned 64-bit integer literal from a character stream.
// ----------------------------------------------------------------------------
// Usage: one ASCII character per slave transfer (tdata), tuser set on the
// first character of a new string to restart the parser. Leading whitespace
// is skipped; the prefix '%', 0b, '$', 0x, 0o or a bare 0 picks the radix.
// The first character that does not belong to the literal produces one
// master transfer: value and consumed count in tdata, radix kind in tuser.
// Later characters give nothing until a new string starts.
// Output: a terminating character is accepted into the input register and
// its result enters the result register once that register is free.
// Throughput: one character per cycle unless the result side stalls; the parser
// state is updated by a combinational next-state step between the registers.
// Reset: clears both registers and returns the parser to whitespace skip,
// so the first string needs no start flag.
// Stall: while a result waits, one more character is still taken into the
// input register; beyond that tready drops until the result is taken.
// ----------------------------------------------------------------------------
module radix_prefixed_literal_parser #(
  parameter int MAX_CHARS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] start_new
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] value, [71:64] consumed_count
  output logic [1:0]  m_axis_tuser    // [1:0] radix_kind
);
  import rplp_pkg::*;

  localparam logic [7:0] CountCap = (MAX_CHARS < 255) ? 8'(MAX_CHARS) : 8'd255;

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_start_q;
  logic        adv;
  logic        step;
  logic        emit;
  rplp_state_t st_q;
  rplp_state_t st_d;
  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic [7:0]  out_count_q;
  logic [1:0]  out_radix_q;

  // advance the result register when it is empty or being drained
  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  rplp_step #(
    .CountCap(CountCap)
  ) u_step (
    .state_i(st_q),
    .char_i (in_char_q),
    .start_i(in_start_q),
    .state_o(st_d),
    .emit_o (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (step) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_value_q <= st_d.acc;
      out_count_q <= st_d.cnt;
      out_radix_q <= st_d.radix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_value_q};
  assign m_axis_tuser  = out_radix_q;

`include "radix_prefixed_literal_parser_assert.svh"

  `RPLP_ASSERT_NEXT(a_emit_done, step && emit, st_q.phase == PH_DONE, "parser not done after result")
  `RPLP_ASSERT_SAME(a_done_quiet, step && st_q.phase == PH_DONE && !in_start_q, !emit, "result after terminator")
  `RPLP_ASSERT_SAME(a_count_cap, 1'b1, st_q.cnt <= CountCap, "count above cap")
  `RPLP_ASSERT_SAME(a_out_src, $rose(m_axis_tvalid), $past(step && emit), "result without terminator")

endmodule

>>> test/radix_prefixed_literal_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser_checker
// Watches both stream channels of the literal parser, predicts each literal
// it should report from the accepted characters, and compares every result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module radix_prefixed_literal_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] start_new
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // [63:0] value, [71:64] consumed_count
  input  logic [1:0]  m_axis_tuser,   // [1:0] radix_kind
  output int          errors_o,
  output int          pending_o,
  output int          chars_o,
  output int          literals_o
);
  import rplp_pkg::*;

  localparam int         COUNT_CAP     = 255;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_PERCENT    = "%";
  localparam logic [7:0] CH_DOLLAR     = "$";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [4:0] NOT_A_DIGIT   = 5'd16;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  count;
    radix_e      radix;
  } literal_t;

  literal_t    literal_q[$];
  logic [1:0]  phase;
  logic [63:0] acc;
  logic [7:0]  consumed;
  radix_e      radix;
  logic        skip_us;
  int          mismatches = 0;
  int          waiting = 0;
  int          chars_seen = 0;
  int          literals_seen = 0;

  assign errors_o   = mismatches;
  assign pending_o  = waiting;
  assign chars_o    = chars_seen;
  assign literals_o = literals_seen;

  function automatic logic [63:0] base_of(input radix_e r);
    case (r)
      RX_HEX:  return 64'd16;
      RX_OCT:  return 64'd8;
      RX_BIN:  return 64'd2;
      default: return 64'd10;
    endcase
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_e r);
    logic [4:0] d;
    d = NOT_A_DIGIT;
    if (c >= "0" && c <= "9") begin
      d = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = 5'(c - "a" + 10);
    end else if (c >= "A" && c <= "F") begin
      d = 5'(c - "A" + 10);
    end
    if (64'(d) >= base_of(r)) begin
      d = NOT_A_DIGIT;
    end
    return d;
  endfunction

  task automatic clear_parser();
    phase    = PH_SKIP;
    acc      = '0;
    consumed = '0;
    radix    = RX_DEC;
    skip_us  = 1'b0;
  endtask

  task automatic take_char();
    if (consumed < COUNT_CAP) begin
      consumed = consumed + 8'd1;
    end
  endtask

  task automatic enter_digits(input radix_e r, input logic us);
    radix   = r;
    skip_us = us;
    phase   = PH_DIGITS;
  endtask

  task automatic close_literal();
    literal_t lit;
    lit.value = acc;
    lit.count = consumed;
    lit.radix = radix;
    literal_q.push_back(lit);
    phase = PH_DONE;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic restart);
    logic [4:0] d;
    if (restart) begin
      clear_parser();
    end
    case (phase)
      PH_SKIP: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          take_char();
        end else if (c == CH_PERCENT) begin
          take_char();
          enter_digits(RX_BIN, 1'b1);
        end else if (c == CH_DOLLAR) begin
          take_char();
          enter_digits(RX_HEX, 1'b1);
        end else if (c == CH_ZERO) begin
          take_char();
          radix = RX_OCT;
          phase = PH_ZERO;
        end else if (c >= "1" && c <= "9") begin
          take_char();
          acc = 64'(c - CH_ZERO);
          enter_digits(RX_DEC, 1'b0);
        end else begin
          radix = RX_DEC;
          close_literal();
        end
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          take_char();
          enter_digits(RX_HEX, 1'b1);
        end else if (c == "o" || c == "O") begin
          take_char();
          enter_digits(RX_OCT, 1'b1);
        end else if (c == "b" || c == "B") begin
          take_char();
          enter_digits(RX_BIN, 1'b1);
        end else if (c >= "0" && c <= "7") begin
          take_char();
          acc = 64'(c - CH_ZERO);
          enter_digits(RX_OCT, 1'b0);
        end else begin
          close_literal();
        end
      end
      PH_DIGITS: begin
        d = digit_of(c, radix);
        if (c == CH_UNDERSCORE && skip_us) begin
          take_char();
        end else if (d != NOT_A_DIGIT) begin
          take_char();
          acc = acc * base_of(radix) + 64'(d);
        end else begin
          close_literal();
        end
      end
      default: phase = PH_DONE;
    endcase
  endtask

  task automatic check_literal();
    literal_t lit;
    literals_seen++;
    if (literal_q.size() == 0) begin
      $error("unexpected result: value %0h count %0d radix %0d",
             m_axis_tdata[63:0], m_axis_tdata[71:64], m_axis_tuser);
      mismatches++;
    end else begin
      lit = literal_q.pop_front();
      if (m_axis_tdata[63:0] !== lit.value) begin
        $error("value mismatch: expected %0h, got %0h", lit.value, m_axis_tdata[63:0]);
        mismatches++;
      end
      if (m_axis_tdata[71:64] !== lit.count) begin
        $error("consumed_count mismatch: expected %0d, got %0d",
               lit.count, m_axis_tdata[71:64]);
        mismatches++;
      end
      if (m_axis_tuser !== lit.radix) begin
        $error("radix_kind mismatch: expected %0d, got %0d", lit.radix, m_axis_tuser);
        mismatches++;
      end
    end
  endtask

  // Retire the result first: a result leaving at this edge is always older
  // than anything the character taken at the same edge can produce.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      literal_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_literal();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        chars_seen++;
        parse_char(s_axis_tdata, s_axis_tuser);
      end
    end
    waiting = literal_q.size();
  end

endmodule

>>> test/radix_prefixed_literal_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser_tb
// Drives character strings into the literal parser: a short directed set of
// corner strings, then randomly shaped literals in every radix with random
// whitespace, underscores, terminators, truncation and trailing noise. The
// sender works in bursts and the receiver stalls on its own pattern, with one
// long hold-off to back the parser up. The checker reports mismatches.
// ----------------------------------------------------------------------------
module radix_prefixed_literal_parser_tb;
  import rplp_pkg::*;

  localparam int         RANDOM_CHARS  = 750;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES  = 8;
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_COMMA      = ",";
  localparam logic [7:0] CH_PERCENT    = "%";
  localparam logic [7:0] CH_DOLLAR     = "$";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [7:0] CH_LOWER_A    = "a";
  localparam logic [7:0] CH_UPPER_A    = "A";

  typedef enum int {
    SHAPE_PCT, SHAPE_DOLLAR, SHAPE_0X, SHAPE_0O, SHAPE_0B,
    SHAPE_BARE0, SHAPE_DEC, SHAPE_NONE
  } lit_shape_e;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_code
  logic        s_axis_tuser;    // [0] start_new
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;    // [63:0] value, [71:64] consumed_count
  logic [1:0]  m_axis_tuser;    // [1:0] radix_kind

  int errors;
  int pending;
  int chars_done;
  int literals_done;
  int chars_sent = 0;
  int burst_left = 0;
  int stuck_cycles = 0;
  bit hold_req = 1'b0;

  radix_prefixed_literal_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  radix_prefixed_literal_parser_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending),
    .chars_o       (chars_done),
    .literals_o    (literals_done)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // Offer one character and hold it until the transfer; gaps fall between bursts.
  task automatic send_char(input logic [7:0] c, input logic restart);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit restart);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], restart && (i == 0));
    end
  endtask

  function automatic logic [7:0] digit_char(input radix_e r);
    int lim;
    int d;
    case (r)
      RX_HEX:  lim = 16;
      RX_OCT:  lim = 8;
      RX_BIN:  lim = 2;
      default: lim = 10;
    endcase
    d = $urandom_range(0, lim - 1);
    if (d < 10) begin
      return 8'(CH_ZERO + d);
    end
    return 8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + d - 10);
  endfunction

  task automatic send_literal(input int ws_len);
    logic [7:0] text[$];
    lit_shape_e shape;
    radix_e     r;
    bit         us_ok;
    int         pick;
    int         ndig;
    pick  = $urandom_range(0, 8);
    shape = (pick == 8) ? SHAPE_DEC : lit_shape_e'(pick);
    r     = RX_DEC;
    us_ok = 1'b1;
    repeat (ws_len) begin
      text.push_back($urandom_range(0, 3) ? CH_SPACE : 8'($urandom_range(9, 13)));
    end
    case (shape)
      SHAPE_PCT: begin
        text.push_back(CH_PERCENT);
        r = RX_BIN;
      end
      SHAPE_DOLLAR: begin
        text.push_back(CH_DOLLAR);
        r = RX_HEX;
      end
      SHAPE_0X: begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? "x" : "X");
        r = RX_HEX;
      end
      SHAPE_0O: begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? "o" : "O");
        r = RX_OCT;
      end
      SHAPE_0B: begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? "b" : "B");
        r = RX_BIN;
      end
      SHAPE_BARE0: begin
        text.push_back(CH_ZERO);
        r     = RX_OCT;
        us_ok = 1'b0;
      end
      SHAPE_DEC: begin
        text.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
        us_ok = 1'b0;
      end
      default: us_ok = 1'b0;
    endcase
    // mostly short literals, now and then long ones that can wrap 64 bits
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 8);
    if (shape == SHAPE_NONE) begin
      ndig = 0;
    end
    repeat (ndig) begin
      if (us_ok && $urandom_range(0, 4) == 0) begin
        text.push_back(CH_UNDERSCORE);
      end
      text.push_back(digit_char(r));
    end
    case ($urandom_range(0, 3))
      0:       text.push_back(CH_COMMA);
      1:       text.push_back(CH_SPACE);
      default: text.push_back(8'($urandom_range(0, 255)));
    endcase
    // cut some strings short so the next restart abandons them
    if ($urandom_range(0, 9) == 0) begin
      text = text[0:$urandom_range(0, text.size() - 1)];
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) begin
      send_char(text[i], (i == 0) && ($urandom_range(0, 7) != 0));
    end
  endtask

  // Result side: stall on a pattern that is drawn anew at random.
  initial begin : result_sink
    sink_mode_e mode;
    int         left;
    int         tick;
    bit         held;
    mode = SINK_OPEN;
    left = 0;
    tick = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        tick++;
        case (mode)
          SINK_OPEN:   m_axis_tready <= 1'b1;
          SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= tick[0];
        endcase
      end
    end
  end

  // End the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int lit_idx;
    int target;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first string straight after reset, no restart flag, then an ignored char
    send_text(" 12;z", 1'b0);
    send_char(8'h00, 1'b1);
    send_text("0x_fF,", 1'b1);
    send_text("07", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("0g", 1'b1);
    send_text("%", 1'b1);
    send_char(8'h0D, 1'b0);
    send_text("0b1_0.", 1'b1);

    target  = chars_sent + RANDOM_CHARS;
    lit_idx = 0;
    while (chars_sent < target) begin
      // one long whitespace run drives the consumed count into saturation
      send_literal((lit_idx == 12) ? 260 : $urandom_range(0, 3));
      if (lit_idx == 30) begin
        hold_req = 1'b1;
      end
      lit_idx++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters; %0d literals came back in all four radixes.",
             chars_done, literals_done);
    $display("Included empty, lone-zero, prefix-only, wrapped and saturated literals"
             , " and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
